### rtl/core/bpt_pkg.sv
// Package for the biquadratic patch tessellator.
// Holds the channel item types, register indexes, controller types and lane decoding.
// No dependencies.
package bpt_pkg;

    localparam int NLANE = 14;
    localparam int NSLOT = 9;
    localparam int CP_W = 288;
    localparam int VAL_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TESS_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic [4:0] TESS_LEVEL_RESET = 5'd5;
    localparam logic [15:0] SCALE_RESET = 16'd256;
    localparam logic [CNT_W-1:0] DIV_LAST = 6'd32;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  slot;
        logic [8:0]  grid_point;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic [31:0] tex_uv;
        logic [31:0] light_uv;
        logic [31:0] rgba;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_norm_x;
        logic signed [31:0] out_norm_y;
        logic signed [31:0] out_norm_z;
        logic [31:0] out_tex_uv;
        logic [31:0] out_light_uv;
        logic [31:0] out_rgba;
        logic        bad_point;
    } rsp_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRID,
        ST_WGT,
        ST_MAC,
        ST_DIV,
        ST_STORE,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       take;
        logic       grid_step;
        logic       wgt_load;
        logic       row_pass;
        logic       mac_en;
        logic [1:0] term;
        logic [1:0] col;
        logic       div_load;
        logic       div_step;
        logic       store_col;
        logic       store_final;
        logic       scale_en;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic grid_done;
        logic point_bad;
    } ctrl_status_t;

    // Lanes hold every component as an unsigned value: signed fields carry a flipped
    // sign bit, so every pass works on offset, non-negative numbers.
    function automatic logic [VAL_W-1:0] lane_value(input logic [CP_W-1:0] cp,
                                                   input int unsigned l);
        logic [VAL_W-1:0] v;
        v = '0;
        if (l < 6)
        begin
            v = cp[CP_W-1-32*l -: 32] ^ 32'h8000_0000;
        end
        else if (l < 10)
        begin
            v = {16'h0000, cp[95-16*(l-6) -: 16] ^ 16'h8000};
        end
        else
        begin
            v = {24'h000000, cp[31-8*(l-10) -: 8]};
        end
        return v;
    endfunction

    function automatic logic lane_rounds(input int unsigned l);
        return (l < 10);
    endfunction

endpackage

### rtl/core/bpt_chan_if.sv
// Valid/ready channel carrying one item of a package type.
// Depends on nothing; item types come from bpt_pkg at the instantiation.
interface bpt_chan_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpt_ram #(
    parameter int WIDTH = 288,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/bpt_ctrl.sv
// Controller state machine of the patch tessellator.
// Depends on bpt_pkg; drives the datapath through ctrl_cmd_t.
module bpt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_type,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  bpt_pkg::ctrl_status_t status,
    output bpt_pkg::ctrl_cmd_t    cmd
);

    bpt_pkg::state_t             state_reg, state_next;
    logic [bpt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                  col_reg, col_next;
    logic                        row_reg, row_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        take;

    assign req_ready = (state_reg == bpt_pkg::ST_IDLE);
    assign take = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpt_pkg::ST_IDLE;
            cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            col_reg <= col_next;
            row_reg <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        col_next = col_reg;
        row_next = row_reg;
        unique case (state_reg)
            bpt_pkg::ST_IDLE:
            begin
                if (take && (req_type == bpt_pkg::REQ_EVAL))
                begin
                    state_next = status.point_bad ? bpt_pkg::ST_DONE : bpt_pkg::ST_GRID;
                    col_next = '0;
                    row_next = 1'b0;
                end
            end
            bpt_pkg::ST_GRID:
            begin
                if (status.grid_done)
                begin
                    state_next = bpt_pkg::ST_WGT;
                end
            end
            bpt_pkg::ST_WGT:
            begin
                state_next = bpt_pkg::ST_MAC;
                cnt_next = '0;
            end
            bpt_pkg::ST_MAC:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = bpt_pkg::ST_DIV;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bpt_pkg::ST_DIV:
            begin
                if (cnt_reg == bpt_pkg::DIV_LAST)
                begin
                    state_next = bpt_pkg::ST_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bpt_pkg::ST_STORE:
            begin
                cnt_next = '0;
                if (row_reg)
                begin
                    state_next = bpt_pkg::ST_SCALE;
                end
                else if (col_reg == 2'd2)
                begin
                    state_next = bpt_pkg::ST_WGT;
                    row_next = 1'b1;
                    col_next = '0;
                end
                else
                begin
                    state_next = bpt_pkg::ST_MAC;
                    col_next = col_reg + 1'b1;
                end
            end
            bpt_pkg::ST_SCALE:
            begin
                state_next = bpt_pkg::ST_DONE;
            end
            bpt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    state_next = bpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.take = take;
        cmd.row_pass = row_reg;
        cmd.col = col_reg;
        cmd.term = cnt_reg[1:0];
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            bpt_pkg::ST_IDLE:
            begin
            end
            bpt_pkg::ST_GRID:
            begin
                cmd.grid_step = 1'b1;
            end
            bpt_pkg::ST_WGT:
            begin
                cmd.wgt_load = 1'b1;
            end
            bpt_pkg::ST_MAC:
            begin
                cmd.mac_en = 1'b1;
            end
            bpt_pkg::ST_DIV:
            begin
                cmd.div_load = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
            end
            bpt_pkg::ST_STORE:
            begin
                cmd.store_col = !row_reg;
                cmd.store_final = row_reg;
            end
            bpt_pkg::ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
            end
            bpt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/bpt_datapath.sv
// Datapath of the patch tessellator: control point RAM, weight unit, fourteen
// multiply-accumulate and bit-serial divide lanes, scaling and result register.
// Depends on bpt_pkg and bpt_ram.
module bpt_datapath #(
    parameter int MAX_LEVEL = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpt_pkg::ctrl_cmd_t    cmd,
    output bpt_pkg::ctrl_status_t status,
    input  bpt_pkg::req_item_t    req_data,
    input  logic                  cfg_take,
    input  bpt_pkg::cfg_item_t    cfg_data,
    output bpt_pkg::rsp_item_t    rsp_data
);

    localparam int LW = $clog2(MAX_LEVEL + 1);
    localparam int WW = 2 * LW;
    localparam int AW = 32 + WW;
    localparam int NW = AW + 1;
    localparam int RW = WW + 1;
    localparam int SQW = 2 * (LW + 1);
    localparam int PW = 49;

    logic [4:0]            tess_level_reg;
    logic [15:0]           scale_reg;
    logic [LW-1:0]         lvl;
    logic [LW:0]           lvl1;
    logic [SQW-1:0]        npoints;

    logic [8:0]            gp_rem_reg;
    logic [LW-1:0]         j_reg;
    logic                  bad_reg;

    logic [WW-1:0]         w_reg [3];
    logic [WW-1:0]         d_reg;
    logic [LW-1:0]         wi;
    logic [LW-1:0]         wli;

    logic                  ram_we;
    logic [3:0]            ram_raddr;
    logic [bpt_pkg::CP_W-1:0] ram_wdata;
    logic [bpt_pkg::CP_W-1:0] ram_rdata;

    logic [AW-1:0]         acc_reg [bpt_pkg::NLANE];
    logic [31:0]           num_reg [bpt_pkg::NLANE];
    logic [RW-1:0]         rem_reg [bpt_pkg::NLANE];
    logic [31:0]           colr_reg [3][bpt_pkg::NLANE];
    logic [31:0]           v_reg [bpt_pkg::NLANE];
    logic signed [PW-1:0]  prod_reg [6];
    logic signed [31:0]    scaled [6];
    logic [1:0]            tm1;
    logic [RW-1:0]         dd;

    bpt_pkg::rsp_item_t    rsp_reg;

    function automatic logic signed [31:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] r;
        logic signed [31:0]   s;
        r = (p + PW'(signed'(128))) >>> 8;
        if (r > PW'(signed'(64'sd2147483647)))
        begin
            s = 32'sh7FFF_FFFF;
        end
        else if (r < -PW'(signed'(64'sd2147483648)))
        begin
            s = 32'sh8000_0000;
        end
        else
        begin
            s = r[31:0];
        end
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tess_level_reg <= bpt_pkg::TESS_LEVEL_RESET;
            scale_reg <= bpt_pkg::SCALE_RESET;
        end
        else if (cfg_take)
        begin
            if (cfg_data.index == bpt_pkg::CFG_TESS_LEVEL)
            begin
                tess_level_reg <= cfg_data.value[4:0];
            end
            else if (cfg_data.index == bpt_pkg::CFG_SCALE)
            begin
                scale_reg <= cfg_data.value;
            end
        end
    end

    always_comb
    begin
        priority if (tess_level_reg == 5'd0)
        begin
            lvl = LW'(1);
        end
        else if (32'(tess_level_reg) > MAX_LEVEL)
        begin
            lvl = LW'(MAX_LEVEL);
        end
        else
        begin
            lvl = LW'(tess_level_reg);
        end
    end

    assign lvl1 = {1'b0, lvl} + 1'b1;
    assign npoints = SQW'(lvl1) * SQW'(lvl1);
    assign status.point_bad = (SQW'(req_data.grid_point) >= npoints);
    assign status.grid_done = ((LW + 1 > 9) ? ((LW+1)'(gp_rem_reg) < lvl1)
                                            : (gp_rem_reg < 9'(lvl1)));

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            gp_rem_reg <= req_data.grid_point;
            j_reg <= '0;
            bad_reg <= status.point_bad;
        end
        else if (cmd.grid_step && !status.grid_done)
        begin
            gp_rem_reg <= gp_rem_reg - 9'(lvl1);
            j_reg <= j_reg + 1'b1;
        end
    end

    assign wi = cmd.row_pass ? LW'(gp_rem_reg) : j_reg;
    assign wli = lvl - wi;

    always_ff @(posedge clk)
    begin
        if (cmd.wgt_load)
        begin
            w_reg[0] <= WW'(wli) * WW'(wli);
            w_reg[1] <= (WW'(wi) * WW'(wli)) << 1;
            w_reg[2] <= WW'(wi) * WW'(wi);
            d_reg <= WW'(lvl) * WW'(lvl);
        end
    end

    assign ram_we = cmd.take && (req_data.req_type == bpt_pkg::REQ_LOAD)
                    && (req_data.slot < 4'(bpt_pkg::NSLOT));
    assign ram_wdata = {req_data.pos_x, req_data.pos_y, req_data.pos_z,
                        req_data.norm_x, req_data.norm_y, req_data.norm_z,
                        req_data.tex_uv, req_data.light_uv, req_data.rgba};
    assign ram_raddr = (cmd.term == 2'd3) ? 4'd0 : (4'(cmd.col) + 4'(cmd.term) * 4'd3);

    bpt_ram #(
        .WIDTH(bpt_pkg::CP_W),
        .DEPTH(bpt_pkg::NSLOT)
    ) u_cp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_data.slot),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tm1 = cmd.term - 2'd1;
    assign dd = {d_reg, 1'b0};

    for (genvar l = 0; l < bpt_pkg::NLANE; l++)
    begin : g_lane
        logic [31:0]   opnd;
        logic [NW-1:0] numer;
        logic [RW:0]   trial;
        logic          ge;

        assign opnd = cmd.row_pass ? colr_reg[tm1][l] : bpt_pkg::lane_value(ram_rdata, l);
        assign numer = {acc_reg[l], 1'b0}
                       + (bpt_pkg::lane_rounds(l) ? NW'(d_reg) : NW'(0));
        assign trial = {rem_reg[l], num_reg[l][31]};
        assign ge = (trial >= {1'b0, dd});

        always_ff @(posedge clk)
        begin
            if (cmd.mac_en)
            begin
                if (cmd.term == 2'd0)
                begin
                    acc_reg[l] <= '0;
                end
                else
                begin
                    acc_reg[l] <= acc_reg[l] + AW'(w_reg[tm1]) * AW'(opnd);
                end
            end
            if (cmd.div_load)
            begin
                num_reg[l] <= numer[31:0];
                rem_reg[l] <= numer[NW-1:32];
            end
            else if (cmd.div_step)
            begin
                rem_reg[l] <= ge ? RW'(trial - {1'b0, dd}) : RW'(trial);
                num_reg[l] <= {num_reg[l][30:0], ge};
            end
            if (cmd.store_col)
            begin
                colr_reg[cmd.col][l] <= num_reg[l];
            end
            if (cmd.store_final)
            begin
                v_reg[l] <= num_reg[l];
            end
        end
    end

    for (genvar s = 0; s < 6; s++)
    begin : g_scale
        always_ff @(posedge clk)
        begin
            if (cmd.scale_en)
            begin
                prod_reg[s] <= PW'($signed(v_reg[s] ^ 32'h8000_0000))
                               * PW'($signed({1'b0, scale_reg}));
            end
        end
        assign scaled[s] = round_sat(prod_reg[s]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (bad_reg)
            begin
                rsp_reg <= '{bad_point: 1'b1, default: '0};
            end
            else
            begin
                rsp_reg.out_pos_x <= scaled[0];
                rsp_reg.out_pos_y <= scaled[1];
                rsp_reg.out_pos_z <= scaled[2];
                rsp_reg.out_norm_x <= scaled[3];
                rsp_reg.out_norm_y <= scaled[4];
                rsp_reg.out_norm_z <= scaled[5];
                rsp_reg.out_tex_uv <= {v_reg[6][15:0] ^ 16'h8000, v_reg[7][15:0] ^ 16'h8000};
                rsp_reg.out_light_uv <= {v_reg[8][15:0] ^ 16'h8000, v_reg[9][15:0] ^ 16'h8000};
                rsp_reg.out_rgba <= {v_reg[10][7:0], v_reg[11][7:0],
                                     v_reg[12][7:0], v_reg[13][7:0]};
                rsp_reg.bad_point <= 1'b0;
            end
        end
    end

    assign rsp_data = rsp_reg;

endmodule

### rtl/core/biquadratic_patch_tessellator_unit.sv
// Biquadratic Bezier patch tessellator, top level.
// A load writes the control point in its slot on acceptance. An evaluate steps the grid
// to find its row, then runs four passes of multiply-accumulate, a 32-step divide and a
// store in every lane, plus two weight loads, a scale step and an output step. A point
// outside the grid skips to the output step. One evaluate is in flight at a time.
// Reset restores tess_level 5 and scale 256; control points are undefined until loaded.
module biquadratic_patch_tessellator_unit #(
    parameter int MAX_LEVEL = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bpt_chan_if.sink   req,
    bpt_chan_if.source rsp,
    bpt_chan_if.sink   cfg
);

    bpt_pkg::ctrl_cmd_t    cmd;
    bpt_pkg::ctrl_status_t status;

    assign cfg.ready = 1'b1;

    bpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.data.req_type),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bpt_datapath #(
        .MAX_LEVEL(MAX_LEVEL)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .req_data (req.data),
        .cfg_take (cfg.valid && cfg.ready),
        .cfg_data (cfg.data),
        .rsp_data (rsp.data)
    );

endmodule
